// ===== rtl/bsof_pkg.sv =====
// Shared constants and types for the bitstream sync offset finder.
// No dependencies; compiled first.
`default_nettype none

package bsof_pkg;

  // Header window and alignment of the reported offset
  localparam int HEADER_BYTES = 512;
  localparam int ALIGN_BYTES  = 16;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 9;
  localparam int SYNC_W   = 24;

  // Byte position must hold HEADER_BYTES itself (search stops there)
  localparam int POS_W      = $clog2(HEADER_BYTES + 1);
  localparam int HIST_DEPTH = 4;
  localparam int SYNC_LEAD  = 3;

  // Constant divide by ALIGN_BYTES as multiply by a rounded-up reciprocal;
  // exact for any POS_W-bit dividend
  localparam int ALIGN_L = $clog2(ALIGN_BYTES);
  localparam int DIV_S   = POS_W + ALIGN_L;
  localparam int RECIP_W = POS_W + 1;
  localparam logic [RECIP_W-1:0] ALIGN_RECIP =
      RECIP_W'(((2 ** DIV_S) + ALIGN_BYTES - 1) / ALIGN_BYTES);

  // Sync word AA 99 55 66 and the padding byte
  localparam logic [SYNC_W-1:0] SYNC_HEAD = 24'hAA9955;
  localparam logic [BYTE_W-1:0] SYNC_TAIL = 8'h66;
  localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'hFF;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] data_offset;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bsof_ifs.sv =====
// Valid/ready channel interfaces for header bytes in and offset words out.
// Depends on bsof_pkg.
`default_nettype none

interface bsof_in_if;
  logic                         valid;
  logic                         ready;
  logic [bsof_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface bsof_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [bsof_pkg::OFFSET_W-1:0]  data_offset;

  modport source (output valid, found, data_offset, input ready);
  modport sink   (input valid, found, data_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/bitstream_sync_offset_finder.sv =====
// Top level: searches configuration-file header bytes for the sync word and
// reports how many header bytes to skip. Depends on bsof_pkg and bsof_ifs.
//
//   channel   dir   word                         accepted when
//   in_if     in    data_byte[7:0], last_byte    valid && ready
//   out_if    out   found, data_offset[8:0]      valid && ready
//
// One header byte is taken every cycle while the skid word is empty; a result word is
// registered into the head or skid word of the output queue.
// A two-word output queue (head + skid) lets bytes keep flowing while a
// result waits; in_if.ready drops only when both words are held.
// rst_n is synchronous, active low, and clears search state and the queue.
// The alignment divide is precomputed one byte ahead, so the sync byte path
// holds one constant multiply, two subtracts and the queue steering.
`default_nettype none

module bitstream_sync_offset_finder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bsof_in_if.sink          in_if,
  bsof_out_if.source       out_if
);

  // Search state
  bsof_pkg::pos_t                  pos_r, pos_nxt;
  logic [bsof_pkg::SYNC_W-1:0]     recent_r, recent_nxt;
  bsof_pkg::pos_t                  hist_r   [bsof_pkg::HIST_DEPTH];
  bsof_pkg::pos_t                  hist_nxt [bsof_pkg::HIST_DEPTH];
  logic                            done_r, done_nxt;
  bsof_pkg::pos_t                  quot_r, quot_nxt;

  // Output queue
  bsof_pkg::result_t               head_r, head_nxt;
  bsof_pkg::result_t               skid_r, skid_nxt;
  logic                            head_v_r, head_v_nxt;
  logic                            skid_v_r, skid_v_nxt;

  // Per-byte decode
  logic                            accept;
  logic                            active;
  logic                            sync_hit;
  logic                            advance;
  logic                            push;
  logic                            pop;
  bsof_pkg::pos_t                  run;
  bsof_pkg::pos_t                  sync_pos;
  bsof_pkg::pos_t                  aligned;
  bsof_pkg::pos_t                  offset_full;
  bsof_pkg::result_t               res;

  // Quotient precompute
  bsof_pkg::pos_t                  pos_i_nxt;
  bsof_pkg::pos_t                  j_nxt;
  logic [bsof_pkg::POS_W+bsof_pkg::RECIP_W-1:0] prod_nxt;

  // Handshakes
  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = !skid_v_r;
  assign pop         = head_v_r && out_if.ready;

  // Decode the incoming byte against the current search state
  always_comb begin
    active   = !done_r && (pos_r < bsof_pkg::POS_W'(bsof_pkg::HEADER_BYTES));
    sync_hit = active && (pos_r >= bsof_pkg::POS_W'(bsof_pkg::SYNC_LEAD))
               && (recent_r == bsof_pkg::SYNC_HEAD)
               && (in_if.data_byte == bsof_pkg::SYNC_TAIL);
    advance  = active && !sync_hit;
    run      = (in_if.data_byte == bsof_pkg::PAD_BYTE) ?
               hist_r[0] + bsof_pkg::POS_W'(1) : '0;

    sync_pos    = pos_r - bsof_pkg::POS_W'(bsof_pkg::SYNC_LEAD);
    aligned     = bsof_pkg::POS_W'(quot_r * bsof_pkg::ALIGN_BYTES);
    offset_full = sync_pos - aligned;

    res.found       = sync_hit;
    res.data_offset = sync_hit ? bsof_pkg::OFFSET_W'(offset_full) : '0;
    push            = accept && (sync_hit || (in_if.last_byte && !done_r));
  end

  // Advance, finish or clear the search state
  always_comb begin
    pos_nxt    = pos_r;
    recent_nxt = recent_r;
    done_nxt   = done_r;
    for (int k = 0; k < bsof_pkg::HIST_DEPTH; k++) begin
      hist_nxt[k] = hist_r[k];
    end
    if (accept) begin
      if (in_if.last_byte) begin
        pos_nxt    = '0;
        recent_nxt = '0;
        done_nxt   = 1'b0;
        for (int k = 0; k < bsof_pkg::HIST_DEPTH; k++) begin
          hist_nxt[k] = '0;
        end
      end else if (sync_hit) begin
        done_nxt = 1'b1;
      end else if (advance) begin
        pos_nxt    = pos_r + bsof_pkg::POS_W'(1);
        recent_nxt = {recent_r[bsof_pkg::SYNC_W-bsof_pkg::BYTE_W-1:0], in_if.data_byte};
        hist_nxt[0] = run;
        for (int k = 1; k < bsof_pkg::HIST_DEPTH; k++) begin
          hist_nxt[k] = hist_r[k-1];
        end
      end
    end
  end

  // Precompute floor(j / ALIGN_BYTES) for a sync word ending on the next byte
  always_comb begin
    pos_i_nxt = (pos_nxt >= bsof_pkg::POS_W'(bsof_pkg::SYNC_LEAD)) ?
                pos_nxt - bsof_pkg::POS_W'(bsof_pkg::SYNC_LEAD) : '0;
    j_nxt     = (hist_nxt[bsof_pkg::HIST_DEPTH-1] >= pos_i_nxt) ?
                pos_i_nxt : hist_nxt[bsof_pkg::HIST_DEPTH-1] + bsof_pkg::POS_W'(1);
    prod_nxt  = j_nxt * bsof_pkg::ALIGN_RECIP;
    quot_nxt  = bsof_pkg::POS_W'(prod_nxt >> bsof_pkg::DIV_S);
  end

  // Steer result words through head and skid
  always_comb begin
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_v_nxt = push;
        skid_nxt   = res;
      end else begin
        head_v_nxt = push;
        head_nxt   = res;
      end
    end else if (!head_v_r) begin
      head_v_nxt = push;
      head_nxt   = res;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = res;
    end
  end

  // Hold state; payload words need no reset
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      pos_r    <= '0;
      recent_r <= '0;
      done_r   <= 1'b0;
      quot_r   <= '0;
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
      for (int k = 0; k < bsof_pkg::HIST_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      pos_r    <= pos_nxt;
      recent_r <= recent_nxt;
      done_r   <= done_nxt;
      quot_r   <= quot_nxt;
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
      for (int k = 0; k < bsof_pkg::HIST_DEPTH; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

  // Drive the result channel
  assign out_if.valid       = head_v_r;
  assign out_if.found       = head_r.found;
  assign out_if.data_offset = head_r.data_offset;

endmodule

`default_nettype wire

// ===== rtl/bsof_checker.sv =====
// Port-level checks for bitstream_sync_offset_finder, bound to the top level.
// Depends on bsof_pkg and the top level.
`default_nettype none

module bsof_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_found,
  input wire logic [bsof_pkg::OFFSET_W-1:0] out_data_offset
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
                                && $stable(out_data_offset))
    else $error("result word changed while stalled");

  // Report zero offset on a not-found word
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_data_offset == '0)
    else $error("not-found word carries an offset");

  // Raise a result only after a byte was taken
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without an accepted byte");

  // Come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bitstream_sync_offset_finder bsof_checker u_bsof_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_found       (out_if.found),
  .out_data_offset (out_if.data_offset)
);

`default_nettype wire

// ===== tb/sv/bitstream_sync_offset_finder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bitstream_sync_offset_finder: streams header words,
// predicts each sync offset or not-found word and checks it against the block.
// Depends on bsof_pkg, bsof_ifs and the block itself.

module bitstream_sync_offset_finder_tb;

  localparam int ITEM_TARGET = 1850;
  localparam int TINY_HEADERS = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [bsof_pkg::BYTE_W-1:0] data;
    logic                        last;
  } hdr_word_t;

  logic clk;
  logic rst_n;

  bsof_in_if  in_ch();
  bsof_out_if out_ch();

  bitstream_sync_offset_finder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Pending header words and the offset words they are expected to cause
  hdr_word_t         hdr_q[$];
  bsof_pkg::result_t offset_q[$];

  int errors = 0;
  int in_taken = 0;
  int pressure_at = 0;
  int hold_left = 0;
  int in_gap = 0;
  int out_gap = 0;
  int cycle_cnt = 0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;

  // Predictor copy of the search state
  int                          srch_pos = 0;
  logic [bsof_pkg::SYNC_W-1:0] recent_win = '0;
  int                          pad_runs[bsof_pkg::HIST_DEPTH] = '{default: 0};
  bit                          sync_seen = 1'b0;

  // Advance the search by one header word; report the word it produces, if any
  task automatic predict_offset(input logic [bsof_pkg::BYTE_W-1:0] d, input logic last,
                                output bit hit, output bsof_pkg::result_t res);
    int sync_at;
    int run_len;
    int span;
    int new_run;
    hit = 1'b0;
    res = '0;
    if (!sync_seen && srch_pos < bsof_pkg::HEADER_BYTES) begin
      if (srch_pos >= bsof_pkg::SYNC_LEAD && recent_win == bsof_pkg::SYNC_HEAD
          && d == bsof_pkg::SYNC_TAIL) begin
        sync_at = srch_pos - bsof_pkg::SYNC_LEAD;
        run_len = pad_runs[3];
        // padding that reaches the header start counts as the whole prefix
        span = (run_len >= sync_at) ? sync_at : run_len + 1;
        res.found = 1'b1;
        res.data_offset = bsof_pkg::OFFSET_W'(sync_at -
            (span / bsof_pkg::ALIGN_BYTES) * bsof_pkg::ALIGN_BYTES);
        hit = 1'b1;
        sync_seen = 1'b1;
      end else begin
        new_run = (d == bsof_pkg::PAD_BYTE) ? pad_runs[0] + 1 : 0;
        pad_runs[3] = pad_runs[2];
        pad_runs[2] = pad_runs[1];
        pad_runs[1] = pad_runs[0];
        pad_runs[0] = new_run;
        recent_win = {recent_win[bsof_pkg::SYNC_W-bsof_pkg::BYTE_W-1:0], d};
        srch_pos++;
      end
    end
    // Close the header: report not-found if nothing was reported, then clear
    if (last) begin
      if (!hit && !sync_seen) begin
        hit = 1'b1;
        res = '0;
      end
      srch_pos = 0;
      recent_win = '0;
      pad_runs = '{default: 0};
      sync_seen = 1'b0;
    end
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // Random byte biased toward the sync and padding values
  function automatic logic [bsof_pkg::BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 11))
      0: return bsof_pkg::SYNC_HEAD[23:16];
      1: return bsof_pkg::SYNC_HEAD[15:8];
      2: return bsof_pkg::SYNC_HEAD[7:0];
      3: return bsof_pkg::SYNC_TAIL;
      4: return bsof_pkg::PAD_BYTE;
      default: return bsof_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [bsof_pkg::BYTE_W-1:0] d);
    hdr_word_t w;
    w.data = d;
    w.last = 1'b0;
    hdr_q.push_back(w);
  endtask

  task automatic push_sync_head();
    push_byte(bsof_pkg::SYNC_HEAD[23:16]);
    push_byte(bsof_pkg::SYNC_HEAD[15:8]);
    push_byte(bsof_pkg::SYNC_HEAD[7:0]);
  endtask

  task automatic push_sync();
    push_sync_head();
    push_byte(bsof_pkg::SYNC_TAIL);
  endtask

  task automatic push_pad(input int n);
    repeat (n) push_byte(bsof_pkg::PAD_BYTE);
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_byte(rand_byte());
  endtask

  // Filler that cannot start a sync word
  task automatic push_filler(input int n);
    logic [bsof_pkg::BYTE_W-1:0] b;
    repeat (n) begin
      b = bsof_pkg::BYTE_W'($urandom_range(0, 255));
      if (b == bsof_pkg::SYNC_HEAD[23:16]) b = '0;
      push_byte(b);
    end
  endtask

  task automatic end_header();
    hdr_q[hdr_q.size()-1].last = 1'b1;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stimulus, reset and end of run
  initial begin
    int kind;
    int n;
    int k;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;

    // Sync at the start, ending on the last byte
    push_sync();
    end_header();
    // Single-byte header without sync
    push_byte(8'h00);
    end_header();
    // Padding that reaches the header start, trailing bytes ignored
    push_pad(2);
    push_sync();
    push_byte(8'h00);
    end_header();
    // Short padding run after data
    push_byte(8'h12);
    push_byte(8'h34);
    push_pad(1);
    push_sync();
    end_header();
    // Near miss on the sync tail
    push_sync_head();
    push_byte(8'h65);
    push_byte(bsof_pkg::PAD_BYTE);
    end_header();

    // Tiny headers while the receiver holds off
    pressure_at = hdr_q.size();
    repeat (TINY_HEADERS) begin
      push_noise($urandom_range(1, 3));
      end_header();
    end

    // Sync ending on the last searched position, padding before it
    k = $urandom_range(0, 40);
    push_filler(bsof_pkg::HEADER_BYTES - 4 - k);
    push_pad(k);
    push_sync();
    push_noise(8);
    end_header();
    // Sync tail falling just outside the window
    push_filler(bsof_pkg::HEADER_BYTES - 3);
    push_sync();
    push_noise(3);
    end_header();

    // Random headers, mostly padding followed by a sync word
    while (hdr_q.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        push_noise(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        case ($urandom_range(0, 3))
          0: n = 0;
          1: n = $urandom_range(1, 15);
          2: n = $urandom_range(14, 34);
          default: n = $urandom_range(40, 70);
        endcase
        push_pad(n);
        push_sync();
        if ($urandom_range(0, 3) != 0) push_noise($urandom_range(1, 6));
      end else if (kind == 6) begin
        // Broken or overlapping sync sequences
        push_noise($urandom_range(0, 5));
        push_sync_head();
        if ($urandom_range(0, 1) != 0) begin
          push_sync();
        end else begin
          push_byte(bsof_pkg::SYNC_TAIL ^ bsof_pkg::BYTE_W'($urandom_range(1, 255)));
          push_noise($urandom_range(1, 4));
        end
      end else if (kind <= 8) begin
        push_noise($urandom_range(1, 30));
      end else begin
        push_pad($urandom_range(1, 40));
      end
      end_header();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain the stimulus, then the expected words, then the pipeline
    while (hdr_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (offset_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && offset_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: offer the next header word, honoring gaps except under hold-off
  always @(posedge clk) begin
    hdr_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap != 0 && hold_left == 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (hdr_q.size() != 0) begin
        nxt = hdr_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.last_byte <= nxt.last;
        in_gap <= gap_len(calm);
        if ($urandom_range(0, 39) == 0) calm <= ~calm;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Hold off the receiver once, when the tiny headers start flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && in_taken >= pressure_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_ch.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ((out_ch.valid && out_ch.ready) || $urandom_range(0, 7) == 0)
        out_gap <= gap_len(calm);
    end
  end

  // Check each result word against the oldest expectation, then predict
  always @(posedge clk) begin
    bit                hit;
    bsof_pkg::result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (offset_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual found=%0b offset=%0d",
                   $time, out_ch.found, out_ch.data_offset);
        end else begin
          want = offset_q.pop_front();
          if (out_ch.found !== want.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, out_ch.found);
          end
          if (out_ch.data_offset !== want.data_offset) begin
            errors++;
            $display("%0t: data_offset mismatch: expected %0d, actual %0d",
                     $time, want.data_offset, out_ch.data_offset);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_offset(in_ch.data_byte, in_ch.last_byte, hit, want);
        if (hit) offset_q.push_back(want);
        in_taken <= in_taken + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/bsof_pkg.sv
rtl/bsof_ifs.sv
rtl/bitstream_sync_offset_finder.sv
rtl/bsof_checker.sv
tb/sv/bitstream_sync_offset_finder_tb.sv
